[design/cnid_pkg.sv]
// shared types, command codes and constants for the can node-id admin handler
// no dependencies
package cnid_pkg;

  localparam int unsigned IdW   = 11;
  localparam int unsigned UuidW = 48;
  localparam int unsigned LenW  = 4;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] CmdQueryUnassigned = 8'h00;
  localparam logic [ByteW-1:0] CmdSetNodeid       = 8'h01;
  localparam logic [ByteW-1:0] CmdRequestBoot     = 8'h02;
  localparam logic [ByteW-1:0] RespNeedNodeid     = 8'h20;
  localparam logic [IdW-1:0]   NodeidBase         = 11'h100;

  localparam logic [IdW-1:0]   AdminFrameIdRst    = 11'd1008;
  localparam logic [IdW-1:0]   AdminReplyIdRst    = 11'd1009;

  typedef enum logic [1:0] {
    CFG_CHIP_UUID      = 2'd0,
    CFG_ADMIN_FRAME_ID = 2'd1,
    CFG_ADMIN_REPLY_ID = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]   frame_id;
    logic [LenW-1:0]  frame_length;
    logic [ByteW-1:0] cmd;
    logic [UuidW-1:0] uuid;
    logic [ByteW-1:0] node_req;
  } frame_t;

  typedef struct packed {
    logic [UuidW-1:0] chip_uuid;
    logic [IdW-1:0]   admin_frame_id;
    logic [IdW-1:0]   admin_reply_id;
  } cfg_t;

  typedef struct packed {
    logic             reply_valid;
    logic [IdW-1:0]   reply_frame_id;
    logic [63:0]      reply_payload;
    logic             filter_update;
    logic [IdW-1:0]   filter_value;
    logic             id_conflict;
    logic             boot_request;
    logic             data_accepted;
    logic [ByteW-1:0] node_number;
  } result_t;

endpackage

[design/can_node_id_admin_handler.sv]
// top level: config registers, input beat register, result register
// depends on cnid_pkg and cnid_core
// A frame passes the input register, then the result register. Throughput is one beat per cycle
// unless out_ready_i stalls, set by the single assigned-id register updated as each frame leaves
// the input register. Configuration writes take effect at once and should be made while idle.
module can_node_id_admin_handler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [cnid_pkg::UuidW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cnid_pkg::IdW-1:0]    frame_id_i,
  input  logic [cnid_pkg::LenW-1:0]   frame_length_i,
  input  logic [7:0]                  byte_zero_i,
  input  logic [7:0]                  byte_one_i,
  input  logic [7:0]                  byte_two_i,
  input  logic [7:0]                  byte_three_i,
  input  logic [7:0]                  byte_four_i,
  input  logic [7:0]                  byte_five_i,
  input  logic [7:0]                  byte_six_i,
  input  logic [7:0]                  byte_seven_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        reply_valid_o,
  output logic [cnid_pkg::IdW-1:0]    reply_frame_id_o,
  output logic [63:0]                 reply_payload_o,
  output logic                        filter_update_o,
  output logic [cnid_pkg::IdW-1:0]    filter_value_o,
  output logic                        id_conflict_o,
  output logic                        boot_request_o,
  output logic                        data_accepted_o,
  output logic [7:0]                  node_number_o
);
  import cnid_pkg::*;

  cfg_t    cfg_q;
  frame_t  frame_q;
  logic    in_vld_q;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    advance;
  logic    in_take;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chip_uuid      <= '0;
      cfg_q.admin_frame_id <= AdminFrameIdRst;
      cfg_q.admin_reply_id <= AdminReplyIdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHIP_UUID:      cfg_q.chip_uuid      <= cfg_wdata_i;
        CFG_ADMIN_FRAME_ID: cfg_q.admin_frame_id <= cfg_wdata_i[IdW-1:0];
        CFG_ADMIN_REPLY_ID: cfg_q.admin_reply_id <= cfg_wdata_i[IdW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input beat register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      frame_q.frame_id     <= frame_id_i;
      frame_q.frame_length <= frame_length_i;
      frame_q.cmd          <= byte_zero_i;
      frame_q.uuid         <= {byte_six_i, byte_five_i, byte_four_i,
                               byte_three_i, byte_two_i, byte_one_i};
      frame_q.node_req     <= byte_seven_i;
    end
  end

  cnid_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .frame_i (frame_q),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign reply_valid_o    = res_q.reply_valid;
  assign reply_frame_id_o = res_q.reply_frame_id;
  assign reply_payload_o  = res_q.reply_payload;
  assign filter_update_o  = res_q.filter_update;
  assign filter_value_o   = res_q.filter_value;
  assign id_conflict_o    = res_q.id_conflict;
  assign boot_request_o   = res_q.boot_request;
  assign data_accepted_o  = res_q.data_accepted;
  assign node_number_o    = res_q.node_number;

endmodule

[design/cnid_core.sv]
// frame decode and assigned node-id register
// depends on cnid_pkg
module cnid_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cnid_pkg::frame_t frame_i,
  input  cnid_pkg::cfg_t   cfg_i,
  output cnid_pkg::result_t res_o
);
  import cnid_pkg::*;

  logic [IdW-1:0] assigned_id_q, assigned_id_d;
  logic [IdW:0]   id_plus_one;
  logic [IdW-1:0] new_id;
  logic [IdW-1:0] nn_diff;
  logic           uuid_match;
  logic           is_conflict;
  logic           is_admin;

  assign id_plus_one = {1'b0, assigned_id_q} + {{IdW{1'b0}}, 1'b1};
  assign new_id      = {2'b00, frame_i.node_req, 1'b0} + NodeidBase;
  assign uuid_match  = (frame_i.frame_length >= 4'd7) && (frame_i.uuid == cfg_i.chip_uuid);
  assign is_conflict = (frame_i.frame_id != '0) && ({1'b0, frame_i.frame_id} == id_plus_one);
  assign is_admin    = (frame_i.frame_id == cfg_i.admin_frame_id) && (frame_i.frame_length != '0);

  always_comb begin
    assigned_id_d = assigned_id_q;
    res_o = '0;
    res_o.data_accepted = (frame_i.frame_id != '0) && (frame_i.frame_id == assigned_id_q);
    if (is_conflict) begin
      assigned_id_d       = '0;
      res_o.filter_update = 1'b1;
      res_o.id_conflict   = 1'b1;
    end else if (is_admin) begin
      case (frame_i.cmd)
        CmdQueryUnassigned: begin
          if (assigned_id_q == '0) begin
            res_o.reply_valid    = 1'b1;
            res_o.reply_frame_id = cfg_i.admin_reply_id;
            res_o.reply_payload  = {CmdSetNodeid, cfg_i.chip_uuid, RespNeedNodeid};
          end
        end
        CmdSetNodeid: begin
          if (frame_i.frame_length >= 4'd8) begin
            if (uuid_match) begin
              if (new_id != assigned_id_q) begin
                assigned_id_d       = new_id;
                res_o.filter_update = 1'b1;
              end
            end else if (new_id == assigned_id_q) begin
              assigned_id_d       = '0;
              res_o.filter_update = 1'b1;
              res_o.id_conflict   = 1'b1;
            end
          end
        end
        CmdRequestBoot: begin
          res_o.boot_request = uuid_match;
        end
        default: begin
        end
      endcase
    end
    nn_diff            = assigned_id_d - NodeidBase;
    res_o.filter_value = assigned_id_d;
    res_o.node_number  = (assigned_id_d == '0) ? '0 : nn_diff[ByteW:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_id_q <= '0;
    end else if (en_i) begin
      assigned_id_q <= assigned_id_d;
    end
  end

  a_hold_without_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !res_o.filter_update) |=> $stable(assigned_id_q))
    else $error("assigned id changed without filter update");

  a_conflict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.id_conflict) |=> (assigned_id_q == '0))
    else $error("conflict did not clear assigned id");

  a_reply_only_unassigned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.reply_valid |-> (assigned_id_q == '0) && !res_o.filter_update)
    else $error("reply while assigned");

  a_assigned_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (assigned_id_q != '0) |-> !assigned_id_q[0] && (assigned_id_q >= NodeidBase))
    else $error("assigned id out of node range");

endmodule

[test/can_node_id_admin_handler_test.sv]
// testbench for can_node_id_admin_handler: directed and random frames, checked beat by beat
// against a predictor of the node-id state kept in this file
// depends on cnid_pkg and the can_node_id_admin_handler rtl
`timescale 1ns / 100ps

module can_node_id_admin_handler_test;
  import cnid_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  cfg_idx_e         cfg_idx_i = CFG_CHIP_UUID;
  logic [UuidW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  frame_t           tx_beat = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             reply_valid_o;
  logic [IdW-1:0]   reply_frame_id_o;
  logic [63:0]      reply_payload_o;
  logic             filter_update_o;
  logic [IdW-1:0]   filter_value_o;
  logic             id_conflict_o;
  logic             boot_request_o;
  logic             data_accepted_o;
  logic [7:0]       node_number_o;

  // predicted state and register copies
  logic [IdW-1:0]   node_id = '0;
  logic [UuidW-1:0] uuid_cfg = '0;
  logic [IdW-1:0]   admin_id_cfg = AdminFrameIdRst;
  logic [IdW-1:0]   reply_id_cfg = AdminReplyIdRst;

  frame_t  frames_waiting[$];
  result_t results_due[$];
  int      frames_offered = 0;
  int      frames_taken = 0;
  int      results_seen = 0;
  int      tx_wait = 0;
  int      rx_wait = 0;
  int      rx_mark = 0;
  bit      calm_tx = 1'b0;
  bit      calm_rx = 1'b0;
  bit      failed = 1'b0;

  always #2 clk_i = ~clk_i;

  can_node_id_admin_handler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_id_i       (tx_beat.frame_id),
    .frame_length_i   (tx_beat.frame_length),
    .byte_zero_i      (tx_beat.cmd),
    .byte_one_i       (tx_beat.uuid[7:0]),
    .byte_two_i       (tx_beat.uuid[15:8]),
    .byte_three_i     (tx_beat.uuid[23:16]),
    .byte_four_i      (tx_beat.uuid[31:24]),
    .byte_five_i      (tx_beat.uuid[39:32]),
    .byte_six_i       (tx_beat.uuid[47:40]),
    .byte_seven_i     (tx_beat.node_req),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reply_valid_o    (reply_valid_o),
    .reply_frame_id_o (reply_frame_id_o),
    .reply_payload_o  (reply_payload_o),
    .filter_update_o  (filter_update_o),
    .filter_value_o   (filter_value_o),
    .id_conflict_o    (id_conflict_o),
    .boot_request_o   (boot_request_o),
    .data_accepted_o  (data_accepted_o),
    .node_number_o    (node_number_o)
  );

  function automatic result_t predict_result(frame_t f);
    result_t        r;
    logic [LenW-1:0] len;
    logic           uuid_ok;
    logic [IdW-1:0] req_id;
    logic [IdW-1:0] offs;
    r = '0;
    len = (f.frame_length > 4'd8) ? 4'd8 : f.frame_length;
    uuid_ok = (len >= 4'd7) && (f.uuid == uuid_cfg);
    r.data_accepted = (f.frame_id != '0) && (f.frame_id == node_id);
    if (f.frame_id != '0 && {1'b0, f.frame_id} == {1'b0, node_id} + 12'd1) begin
      node_id = '0;
      r.filter_update = 1'b1;
      r.id_conflict = 1'b1;
    end else if (f.frame_id == admin_id_cfg && len != '0) begin
      case (f.cmd)
        CmdQueryUnassigned: begin
          if (node_id == '0) begin
            r.reply_valid = 1'b1;
            r.reply_frame_id = reply_id_cfg;
            r.reply_payload = {CmdSetNodeid, uuid_cfg, RespNeedNodeid};
          end
        end
        CmdSetNodeid: begin
          if (len == 4'd8) begin
            req_id = {2'b00, f.node_req, 1'b0} + NodeidBase;
            if (uuid_ok) begin
              if (req_id != node_id) begin
                node_id = req_id;
                r.filter_update = 1'b1;
              end
            end else if (req_id == node_id) begin
              node_id = '0;
              r.filter_update = 1'b1;
              r.id_conflict = 1'b1;
            end
          end
        end
        CmdRequestBoot: begin
          r.boot_request = uuid_ok;
        end
        default: ;
      endcase
    end
    offs = node_id - NodeidBase;
    r.filter_value = node_id;
    r.node_number = (node_id == '0) ? 8'd0 : offs[8:1];
    return r;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic frame_t make_frame();
    frame_t         f;
    logic [IdW-1:0] own_off;
    logic [IdW-1:0] admin_off;
    int unsigned    kind;
    own_off = node_id - NodeidBase;
    admin_off = admin_id_cfg - NodeidBase;
    kind = $urandom_range(0, 9);
    f.frame_id = IdW'($urandom);
    f.frame_length = LenW'($urandom);
    f.cmd = ByteW'($urandom);
    f.uuid = UuidW'({$urandom, $urandom});
    f.node_req = ByteW'($urandom);
    if (kind <= 6) begin
      f.frame_id = admin_id_cfg;
      if ($urandom_range(0, 4) != 0) f.frame_length = LenW'($urandom_range(8, 15));
      case (kind)
        0, 1: f.cmd = CmdQueryUnassigned;
        5: f.cmd = CmdRequestBoot;
        6: f.cmd = ByteW'($urandom_range(3, 255));
        default: f.cmd = CmdSetNodeid;
      endcase
      case ($urandom_range(0, 3))
        0: ;
        1: f.uuid = uuid_cfg ^ (UuidW'(1) << $urandom_range(0, UuidW - 1));
        default: f.uuid = uuid_cfg;
      endcase
      case ($urandom_range(0, 2))
        0: f.node_req = own_off[8:1];
        1: f.node_req = admin_off[8:1];
        default: ;
      endcase
    end else if (kind == 7) begin
      f.frame_id = node_id;
    end else if (kind == 8) begin
      f.frame_id = node_id + IdW'(1);
    end
    return f;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (frames_waiting.size() != 0 || frames_taken != frames_offered ||
               results_due.size() != 0);
  endtask

  task automatic push_frame(frame_t f);
    while (frames_waiting.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    frames_waiting.push_back(f);
  endtask

  task automatic send(logic [IdW-1:0] fid, logic [LenW-1:0] len, logic [ByteW-1:0] cmd,
                      logic [UuidW-1:0] uuid, logic [ByteW-1:0] req);
    frame_t f;
    f.frame_id = fid;
    f.frame_length = len;
    f.cmd = cmd;
    f.uuid = uuid;
    f.node_req = req;
    push_frame(f);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [UuidW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CHIP_UUID: uuid_cfg = value;
      CFG_ADMIN_FRAME_ID: admin_id_cfg = value[IdW-1:0];
      default: reply_id_cfg = value[IdW-1:0];
    endcase
  endtask

  task automatic set_config(logic [UuidW-1:0] uuid, logic [IdW-1:0] admin_fid,
                            logic [IdW-1:0] reply_fid);
    write_reg(CFG_CHIP_UUID, uuid);
    write_reg(CFG_ADMIN_FRAME_ID, UuidW'(admin_fid));
    write_reg(CFG_ADMIN_REPLY_ID, UuidW'(reply_fid));
  endtask

  // input beat driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && frames_taken != frames_offered)) begin
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
        in_valid_i <= 1'b0;
      end else if (frames_waiting.size() != 0) begin
        tx_beat <= frames_waiting.pop_front();
        in_valid_i <= 1'b1;
        frames_offered <= frames_offered + 1;
        tx_wait <= draw_wait(calm_tx);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side ready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (results_seen != rx_mark) begin
        rx_mark = results_seen;
        rx_wait = draw_wait(calm_rx);
      end
      if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        results_due.push_back(predict_result(tx_beat));
        frames_taken <= frames_taken + 1;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1'b1;
        end else begin
          want = results_due.pop_front();
          check_field("reply_valid", 64'(want.reply_valid), 64'(reply_valid_o));
          check_field("reply_frame_id", 64'(want.reply_frame_id), 64'(reply_frame_id_o));
          check_field("reply_payload", want.reply_payload, reply_payload_o);
          check_field("filter_update", 64'(want.filter_update), 64'(filter_update_o));
          check_field("filter_value", 64'(want.filter_value), 64'(filter_value_o));
          check_field("id_conflict", 64'(want.id_conflict), 64'(id_conflict_o));
          check_field("boot_request", 64'(want.boot_request), 64'(boot_request_o));
          check_field("data_accepted", 64'(want.data_accepted), 64'(data_accepted_o));
          check_field("node_number", 64'(want.node_number), 64'(node_number_o));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, chip uuid zero
    send(AdminFrameIdRst, 4'd1, CmdQueryUnassigned, '0, 8'h00);
    send(AdminFrameIdRst, 4'd0, CmdQueryUnassigned, '0, 8'h00);
    send(AdminFrameIdRst, 4'd8, 8'hFF, '1, 8'hFF);
    send(AdminFrameIdRst, 4'd7, CmdSetNodeid, uuid_cfg, 8'h00);
    send(AdminFrameIdRst, 4'd8, CmdSetNodeid, uuid_cfg, 8'h00);
    send(AdminFrameIdRst, 4'd8, CmdSetNodeid, uuid_cfg, 8'h00);
    send(AdminFrameIdRst, 4'd1, CmdQueryUnassigned, '0, 8'h00);
    send(NodeidBase, 4'd0, 8'h00, '0, 8'h00);
    send(AdminFrameIdRst, 4'd15, CmdSetNodeid, uuid_cfg, 8'hFF);
    send(AdminFrameIdRst, 4'd7, CmdRequestBoot, uuid_cfg, 8'h00);
    send(AdminFrameIdRst, 4'd6, CmdRequestBoot, uuid_cfg, 8'h00);
    send(AdminFrameIdRst, 4'd8, CmdRequestBoot, 48'h1, 8'h00);
    send(AdminFrameIdRst, 4'd8, CmdSetNodeid, '1, 8'hFF);
    send(AdminFrameIdRst, 4'd8, CmdSetNodeid, uuid_cfg, 8'h7F);
    send(11'h1FF, 4'd0, 8'h00, '0, 8'h00);
    send(AdminFrameIdRst, 4'd8, CmdSetNodeid, uuid_cfg, 8'hF8);
    send(11'h000, 4'd8, CmdQueryUnassigned, '0, 8'h00);
    send(11'h7FF, 4'd15, 8'hFF, '1, 8'hFF);
    send(11'h2F1, 4'd8, CmdSetNodeid, uuid_cfg, 8'h00);
    send(AdminFrameIdRst, 4'd9, CmdQueryUnassigned, '0, 8'h00);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: set_config('1, 11'h7FF, 11'h000);
        1: set_config('0, 11'h000, 11'h7FF);
        2: set_config(UuidW'({$urandom, $urandom}), NodeidBase + IdW'(2 * $urandom_range(0, 255)),
                      IdW'($urandom));
        3: set_config(UuidW'({$urandom, $urandom}),
                      NodeidBase + IdW'(2 * $urandom_range(0, 255) + 1), IdW'($urandom));
        default: set_config(UuidW'({$urandom, $urandom}), AdminFrameIdRst, AdminReplyIdRst);
      endcase
      for (int n = 0; n < 76; n++) begin
        if (n % 25 == 0) begin
          calm_tx = ($urandom_range(0, 2) == 0);
          calm_rx = ($urandom_range(0, 2) == 0);
        end
        push_frame(make_frame());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
